// ===== hdl/ukte_pkg.sv =====
// ----------------------------------------------------------------------------
// ukte_pkg: shared types and constants of the unique key table engine
// Command codes, status codes, field widths and the control/status bundles
// exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package ukte_pkg;

  // Default table geometry
  localparam int SLOTS_DEF     = 64;
  localparam int KEY_BYTES_DEF = 30;

  // Fixed port field widths
  localparam int FUNC_W      = 3;
  localparam int STATUS_W    = 3;
  localparam int SLOT_OUT_W  = 6;
  localparam int COUNT_OUT_W = 7;
  localparam int PART_W      = 64;
  localparam int PART3_W     = 40;
  localparam int RAW_KEY_W   = 3 * PART_W + PART3_W;

  // Command codes; the remaining codes are invalid
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 3'd0,
    FUNC_SEARCH = 3'd1,
    FUNC_MODIFY = 3'd2,
    FUNC_DELETE = 3'd3,
    FUNC_LIST   = 3'd4
  } func_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_INVALID  = 3'd5
  } status_e;

  // Source of the slot number in a single result
  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_RD   = 2'd1,
    SEL_HIT  = 2'd2,
    SEL_FREE = 2'd3
  } slot_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic      load;       // latch and normalize the input transfer
    logic      scan_clr;   // restart the slot scan
    logic      rd;         // read row at scan pointer, advance pointer
    logic      skip;       // advance pointer without reading
    logic      hit_set;    // remember the slot just compared as hit
    logic      wr_ins;     // write key to lowest free slot
    logic      wr_mod;     // write new key to hit slot
    logic      del;        // free the slot just compared
    logic      res_set;    // latch single-result status and slot
    status_e   res_status;
    slot_sel_e res_slot;
    logic      emit;       // push single result to output register
    logic      list_emit;  // push list entry to output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;       // latched command code
    logic              match_key;  // row read matches the key
    logic              match_new;  // row read matches the new key, other slot
    logic              scan_last;  // row read is the last slot
    logic              cur_valid;  // slot at scan pointer is occupied
    logic              full;       // no free slot
    logic              occ_zero;   // table is empty
    logic              list_last;  // next list entry is the final one
    logic              out_free;   // output register can take a result
  } sts_t;

endpackage

// ===== hdl/ukte_ctrl.sv =====
// ----------------------------------------------------------------------------
// ukte_ctrl: command sequencer of the unique key table engine
// Walks the slot scans for each command, decides the outcome and hands
// results to the datapath output register.
// ----------------------------------------------------------------------------
module ukte_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ukte_pkg::sts_t  sts_i,
  output ukte_pkg::cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DISP = 9'b000000010,
    S_KRD  = 9'b000000100,
    S_KCMP = 9'b000001000,
    S_NRD  = 9'b000010000,
    S_NCMP = 9'b000100000,
    S_LRD  = 9'b001000000,
    S_LOUT = 9'b010000000,
    S_RESP = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.func) inside
          ukte_pkg::FUNC_INSERT, ukte_pkg::FUNC_SEARCH,
          ukte_pkg::FUNC_MODIFY, ukte_pkg::FUNC_DELETE: begin
            state_d = S_KRD;
          end
          ukte_pkg::FUNC_LIST: begin
            if (sts_i.occ_zero) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ukte_pkg::ST_EMPTY;
              cmd_o.res_slot   = ukte_pkg::SEL_ZERO;
              state_d          = S_RESP;
            end else begin
              state_d = S_LRD;
            end
          end
          default: begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ukte_pkg::ST_INVALID;
            cmd_o.res_slot   = ukte_pkg::SEL_ZERO;
            state_d          = S_RESP;
          end
        endcase
      end
      S_KRD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_KCMP;
      end
      // Search for the key, lowest slot first
      S_KCMP: begin
        if (sts_i.match_key) begin
          cmd_o.hit_set = 1'b1;
          cmd_o.res_set = 1'b1;
          state_d       = S_RESP;
          case (sts_i.func)
            ukte_pkg::FUNC_INSERT: begin
              cmd_o.res_status = ukte_pkg::ST_DUP;
              cmd_o.res_slot   = ukte_pkg::SEL_ZERO;
            end
            ukte_pkg::FUNC_DELETE: begin
              cmd_o.del        = 1'b1;
              cmd_o.res_status = ukte_pkg::ST_OK;
              cmd_o.res_slot   = ukte_pkg::SEL_RD;
            end
            ukte_pkg::FUNC_MODIFY: begin
              cmd_o.res_set  = 1'b0;
              cmd_o.scan_clr = 1'b1;
              state_d        = S_NRD;
            end
            default: begin
              cmd_o.res_status = ukte_pkg::ST_OK;
              cmd_o.res_slot   = ukte_pkg::SEL_RD;
            end
          endcase
        end else if (sts_i.scan_last) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_slot = ukte_pkg::SEL_ZERO;
          state_d       = S_RESP;
          if (sts_i.func == ukte_pkg::FUNC_INSERT) begin
            if (sts_i.full) begin
              cmd_o.res_status = ukte_pkg::ST_FULL;
            end else begin
              cmd_o.wr_ins     = 1'b1;
              cmd_o.res_status = ukte_pkg::ST_OK;
              cmd_o.res_slot   = ukte_pkg::SEL_FREE;
            end
          end else begin
            cmd_o.res_status = ukte_pkg::ST_NOTFOUND;
          end
        end else begin
          state_d = S_KRD;
        end
      end
      S_NRD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_NCMP;
      end
      // Modify: new key must not sit in another slot
      S_NCMP: begin
        if (sts_i.match_new) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ukte_pkg::ST_DUP;
          cmd_o.res_slot   = ukte_pkg::SEL_ZERO;
          state_d          = S_RESP;
        end else if (sts_i.scan_last) begin
          cmd_o.wr_mod     = 1'b1;
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ukte_pkg::ST_OK;
          cmd_o.res_slot   = ukte_pkg::SEL_HIT;
          state_d          = S_RESP;
        end else begin
          state_d = S_NRD;
        end
      end
      // List: skip free slots, read occupied ones
      S_LRD: begin
        if (sts_i.cur_valid) begin
          cmd_o.rd = 1'b1;
          state_d  = S_LOUT;
        end else begin
          cmd_o.skip = 1'b1;
        end
      end
      S_LOUT: begin
        if (sts_i.out_free) begin
          cmd_o.list_emit = 1'b1;
          state_d         = sts_i.list_last ? S_IDLE : S_LRD;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/ukte_dpath.sv =====
// ----------------------------------------------------------------------------
// ukte_dpath: key store and compare datapath of the unique key table engine
// Holds the normalized request keys, the key memory, the occupancy bits and
// count, the scan pointer, the comparator and the output register.
// ----------------------------------------------------------------------------
module ukte_dpath #(
  parameter int SLOTS     = ukte_pkg::SLOTS_DEF,
  parameter int KEY_BYTES = ukte_pkg::KEY_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ukte_pkg::cmd_t                      cmd_i,
  output ukte_pkg::sts_t                      sts_o,
  input  logic [ukte_pkg::FUNC_W-1:0]         func_i,
  input  logic [ukte_pkg::RAW_KEY_W-1:0]      key_raw_i,
  input  logic [ukte_pkg::RAW_KEY_W-1:0]      new_raw_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ukte_pkg::STATUS_W-1:0]       status_o,
  output logic [ukte_pkg::SLOT_OUT_W-1:0]     slot_o,
  output logic [ukte_pkg::RAW_KEY_W-1:0]      out_key_o,
  output logic [ukte_pkg::COUNT_OUT_W-1:0]    occupied_count_o,
  output logic                                last_o
);

  localparam int RAW_W    = ukte_pkg::RAW_KEY_W;
  localparam int KEY_BITS = 8 * (KEY_BYTES - 1);
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int SO_W     = ukte_pkg::SLOT_OUT_W;
  localparam int CO_W     = ukte_pkg::COUNT_OUT_W;

  // Cut a key at its first zero byte and at the key length
  function automatic logic [KEY_BITS-1:0] norm_key(logic [RAW_W-1:0] raw);
    logic [KEY_BITS-1:0] res;
    logic                alive;
    res   = '0;
    alive = 1'b1;
    for (int i = 0; i < KEY_BYTES - 1; i++) begin
      alive = alive & (raw[8*i +: 8] != 8'h00);
      if (alive) begin
        res[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return res;
  endfunction

  logic [ukte_pkg::FUNC_W-1:0] func_q;
  logic [KEY_BITS-1:0]         key_q, nkey_q;
  logic [SLOT_W-1:0]           scan_q, rd_slot_q, hit_q, free_idx;
  logic                        rd_vld_q, full;
  logic [KEY_BITS-1:0]         rd_data_q;
  logic [KEY_BITS-1:0]         mem_q [SLOTS];
  logic [SLOTS-1:0]            valid_q;
  logic [CNT_W-1:0]            occ_q, n_q;
  ukte_pkg::status_e           res_status_q;
  logic [SLOT_W-1:0]           res_slot_q;
  logic                        key_empty, nkey_empty, list_last;
  logic                        wr_en;
  logic [SLOT_W-1:0]           wr_addr;
  logic [KEY_BITS-1:0]         wr_data;
  logic [RAW_W-1:0]            rd_ext;
  logic                        out_valid_q;
  logic [ukte_pkg::STATUS_W-1:0]  out_status_q;
  logic [SO_W-1:0]             out_slot_q;
  logic [RAW_W-1:0]            out_key_q;
  logic [CO_W-1:0]             out_count_q;
  logic                        out_last_q;

  assign key_empty  = (key_q[7:0] == 8'h00);
  assign nkey_empty = (nkey_q[7:0] == 8'h00);
  assign list_last  = ((n_q + 1'b1) == occ_q);

  // Request registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      key_q  <= norm_key(key_raw_i);
      nkey_q <= norm_key(new_raw_i);
    end
  end

  // Scan pointer, read tag, hit slot, list counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      n_q    <= '0;
    end else begin
      if (cmd_i.load || cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.rd || cmd_i.skip) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.load) begin
        n_q <= '0;
      end else if (cmd_i.list_emit) begin
        n_q <= n_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_slot_q <= scan_q;
      rd_vld_q  <= valid_q[scan_q];
    end
    if (cmd_i.hit_set) begin
      hit_q <= rd_slot_q;
    end
  end

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = SLOT_W'(i);
        full     = 1'b0;
      end
    end
  end

  // Key memory write port
  always_comb begin
    wr_en   = cmd_i.wr_ins || cmd_i.wr_mod;
    wr_addr = cmd_i.wr_mod ? hit_q : free_idx;
    wr_data = cmd_i.wr_mod ? nkey_q : key_q;
  end

  // Key memory, one row per slot, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[scan_q];
    end
  end

  // Occupancy bits and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else begin
      if (cmd_i.wr_ins) begin
        valid_q[free_idx] <= !key_empty;
        if (!key_empty) begin
          occ_q <= occ_q + 1'b1;
        end
      end
      if (cmd_i.del) begin
        valid_q[rd_slot_q] <= 1'b0;
        occ_q              <= occ_q - 1'b1;
      end
      if (cmd_i.wr_mod) begin
        valid_q[hit_q] <= !nkey_empty;
        if (nkey_empty) begin
          occ_q <= occ_q - 1'b1;
        end
      end
    end
  end

  // Single-result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      case (cmd_i.res_slot)
        ukte_pkg::SEL_RD:   res_slot_q <= rd_slot_q;
        ukte_pkg::SEL_HIT:  res_slot_q <= hit_q;
        ukte_pkg::SEL_FREE: res_slot_q <= free_idx;
        default:            res_slot_q <= '0;
      endcase
    end
  end

  // Read row widened to the port layout
  always_comb begin
    rd_ext                 = '0;
    rd_ext[KEY_BITS-1:0]   = rd_data_q;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.list_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_slot_q   <= SO_W'(res_slot_q);
      out_key_q    <= '0;
      out_count_q  <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.list_emit) begin
      out_status_q <= ukte_pkg::ST_OK;
      out_slot_q   <= SO_W'(rd_slot_q);
      out_key_q    <= rd_ext;
      out_count_q  <= list_last ? CO_W'(occ_q) : '0;
      out_last_q   <= list_last;
    end
  end

  // Status to controller
  always_comb begin
    sts_o.func      = func_q;
    sts_o.match_key = rd_vld_q && (rd_data_q == key_q);
    sts_o.match_new = rd_vld_q && (rd_data_q == nkey_q) && (rd_slot_q != hit_q);
    sts_o.scan_last = (rd_slot_q == SLOT_W'(SLOTS - 1));
    sts_o.cur_valid = valid_q[scan_q];
    sts_o.full      = full;
    sts_o.occ_zero  = (occ_q == '0);
    sts_o.list_last = list_last;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign slot_o           = out_slot_q;
  assign out_key_o        = out_key_q;
  assign occupied_count_o = out_count_q;
  assign last_o           = out_last_q;

endmodule

// ===== hdl/unique_key_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// unique_key_table_engine_unit: table of unique short text keys
// Insert, search, modify, delete and list over a fixed slot table.
// ----------------------------------------------------------------------------
// One command is worked at a time; in_ready_o is high only while the engine is
// free. The keys sit in a single-port memory with one row per slot, and every
// slot compare reads the row into a register and then compares it, so insert,
// search and delete scan the slots from the lowest up, with the scan stopping
// at the lowest matching slot. Modify adds a second full scan for the new key.
// List skips each free slot below the last occupied one, reads each occupied
// slot and waits while the output side stalls. Invalid commands and an empty
// list give a single result without a scan. A finished result waits in the
// output register while the next command is taken. Occupancy bits clear at
// reset; no clearing pass is needed.
module unique_key_table_engine_unit #(
  parameter int SLOTS     = ukte_pkg::SLOTS_DEF,
  parameter int KEY_BYTES = ukte_pkg::KEY_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ukte_pkg::FUNC_W-1:0]       func_i,
  input  logic [ukte_pkg::PART_W-1:0]       key_part0_i,
  input  logic [ukte_pkg::PART_W-1:0]       key_part1_i,
  input  logic [ukte_pkg::PART_W-1:0]       key_part2_i,
  input  logic [ukte_pkg::PART3_W-1:0]      key_part3_i,
  input  logic [ukte_pkg::PART_W-1:0]       new_part0_i,
  input  logic [ukte_pkg::PART_W-1:0]       new_part1_i,
  input  logic [ukte_pkg::PART_W-1:0]       new_part2_i,
  input  logic [ukte_pkg::PART3_W-1:0]      new_part3_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ukte_pkg::STATUS_W-1:0]     status_o,
  output logic [ukte_pkg::SLOT_OUT_W-1:0]   slot_o,
  output logic [ukte_pkg::PART_W-1:0]       out_part0_o,
  output logic [ukte_pkg::PART_W-1:0]       out_part1_o,
  output logic [ukte_pkg::PART_W-1:0]       out_part2_o,
  output logic [ukte_pkg::PART3_W-1:0]      out_part3_o,
  output logic [ukte_pkg::COUNT_OUT_W-1:0]  occupied_count_o,
  output logic                              last_o
);

  localparam int PW = ukte_pkg::PART_W;

  ukte_pkg::cmd_t                  cmd;
  ukte_pkg::sts_t                  sts;
  logic [ukte_pkg::RAW_KEY_W-1:0]  key_raw, new_raw, out_key;

  assign key_raw = {key_part3_i, key_part2_i, key_part1_i, key_part0_i};
  assign new_raw = {new_part3_i, new_part2_i, new_part1_i, new_part0_i};

  // Controller
  ukte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  ukte_dpath #(
    .SLOTS     (SLOTS),
    .KEY_BYTES (KEY_BYTES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .func_i           (func_i),
    .key_raw_i        (key_raw),
    .new_raw_i        (new_raw),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .out_key_o        (out_key),
    .occupied_count_o (occupied_count_o),
    .last_o           (last_o)
  );

  assign out_part0_o = out_key[PW-1:0];
  assign out_part1_o = out_key[2*PW-1:PW];
  assign out_part2_o = out_key[3*PW-1:2*PW];
  assign out_part3_o = out_key[ukte_pkg::RAW_KEY_W-1:3*PW];

`ifndef SYNTHESIS
  // Engine takes one command at a time
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a command is in progress");

  // Occupancy count only rides on a final result
  a_count_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (occupied_count_o != '0)) |-> last_o)
    else $error("occupied count on a non-final result");

  // Failed commands report slot zero
  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ukte_pkg::ST_OK)) |-> (slot_o == '0))
    else $error("nonzero slot on a failed result");

  // Keys only appear on list entries; checked here for failed results
  a_fail_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ukte_pkg::ST_OK)) |-> (out_key == '0))
    else $error("key data on a non-list result");
`endif

endmodule
